// ===== rtl/tfn_pkg.sv =====
package tfn_pkg;
	localparam int C_W = 16;          // cross product magnitude after prescale
	localparam int C_LIMIT_BIT = 16;
	localparam int E_LIMIT_BIT = 30;
	localparam int Q_W = 15;          // unit magnitude 0..16384
	localparam int SQ_W = 2 * C_W;
	localparam int S_W = SQ_W + 2;
	localparam int P_W = 68;
	localparam int R_SHIFT = 30;
	localparam int OUT_W = 16;

	typedef struct packed {
		logic [2:0] neg;
		logic       degen;
	} tfn_tag_t;

	typedef struct packed {
		logic signed [P_W-1:0] p;
		logic signed [P_W-1:0] m;
		logic [Q_W-1:0]        q;
	} tfn_lane_t;
endpackage

// ===== rtl/tfn_tri_if.sv =====
interface tfn_tri_if #(parameter int W = 16) ();
	logic valid;
	logic ready;
	logic signed [W-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;

	modport source(output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		input ready);
	modport sink(input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		output ready);
endinterface

// ===== rtl/tfn_nrm_if.sv =====
interface tfn_nrm_if ();
	logic valid;
	logic ready;
	logic signed [15:0] normal_x, normal_y, normal_z;
	logic degenerate;

	modport source(output valid, normal_x, normal_y, normal_z, degenerate, input ready);
	modport sink(input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// ===== rtl/tfn_cross.sv =====
module tfn_cross #(
	parameter int W = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld,
	input  logic signed [W-1:0]  a [3],
	input  logic signed [W-1:0]  b [3],
	input  logic signed [W-1:0]  c [3],
	output logic                 vld_o,
	output logic [tfn_pkg::C_W-1:0] mag_o [3],
	output tfn_pkg::tfn_tag_t    tag_o
);
	localparam int EM = W + 1;
	localparam int EW = (EM > 31) ? 31 : EM;
	localparam int PW2 = 2 * EW;
	localparam int CW = PW2 + 1;
	localparam int ESH = $clog2(EM);
	localparam int CSH = $clog2(CW);

	logic [5:0] vld_q;

	logic signed [EM-1:0]  e1_s1 [3], e2_s1 [3];
	logic signed [EW-1:0]  e1_s2 [3], e2_s2 [3];
	logic                  deg_s2, deg_s3, deg_s4, deg_s5;
	logic signed [PW2-1:0] pr_s3 [6];
	logic signed [CW-1:0]  cr_s4 [3];
	logic [CW-1:0]         mag_s5 [3];
	logic [2:0]            neg_s5;
	logic [CSH-1:0]        sh_s5;
	logic signed [EW-1:0]  e1_n [3], e2_n [3];
	logic [CW-1:0]         cm [3];
	logic [CSH-1:0]        csh;
	logic                  czero;

	// Edge prescale: common right shift of magnitudes by leading-one position
	function automatic void shrink(input logic signed [EM-1:0] e [3],
		output logic signed [EW-1:0] r [3]);
		logic [EM-1:0]  m [3];
		logic [EM-1:0]  orv;
		logic [ESH-1:0] p;
		logic [ESH-1:0] s;
		logic [EM-1:0]  ms;
		orv = '0;
		p = '0;
		s = '0;
		for (int i = 0; i < 3; i++) begin
			m[i] = e[i][EM-1] ? EM'(-e[i]) : EM'(e[i]);
			orv |= m[i];
		end
		for (int i = 0; i < EM; i++) begin
			if (orv[i]) p = ESH'(i);
		end
		if (int'(p) >= tfn_pkg::E_LIMIT_BIT) s = ESH'(int'(p) - tfn_pkg::E_LIMIT_BIT + 1);
		for (int i = 0; i < 3; i++) begin
			ms = m[i] >> s;
			r[i] = e[i][EM-1] ? -$signed({1'b0, ms[EW-2:0]}) : $signed({1'b0, ms[EW-2:0]});
		end
	endfunction

	always_comb begin
		shrink(e1_s1, e1_n);
		shrink(e2_s1, e2_n);
	end

	always_comb begin
		logic [CW-1:0] orv;
		orv = '0;
		csh = '0;
		for (int i = 0; i < 3; i++) begin
			cm[i] = cr_s4[i][CW-1] ? CW'(-cr_s4[i]) : CW'(cr_s4[i]);
			orv |= cm[i];
		end
		czero = (orv == '0);
		for (int i = 0; i < CW; i++) begin
			if (orv[i] && i >= tfn_pkg::C_LIMIT_BIT)
				csh = CSH'(i - tfn_pkg::C_LIMIT_BIT + 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[4:0], vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= EM'(b[i]) - EM'(a[i]);
				e2_s1[i] <= EM'(c[i]) - EM'(a[i]);
			end
			e1_s2 <= e1_n;
			e2_s2 <= e2_n;
			deg_s2 <= ((e1_s1[0] | e1_s1[1] | e1_s1[2]) == '0) ||
				((e2_s1[0] | e2_s1[1] | e2_s1[2]) == '0);
			pr_s3[0] <= e1_s2[1] * e2_s2[2];
			pr_s3[1] <= e1_s2[2] * e2_s2[1];
			pr_s3[2] <= e1_s2[2] * e2_s2[0];
			pr_s3[3] <= e1_s2[0] * e2_s2[2];
			pr_s3[4] <= e1_s2[0] * e2_s2[1];
			pr_s3[5] <= e1_s2[1] * e2_s2[0];
			deg_s3 <= deg_s2;
			for (int i = 0; i < 3; i++)
				cr_s4[i] <= CW'(pr_s3[2*i]) - CW'(pr_s3[2*i+1]);
			deg_s4 <= deg_s3;
			for (int i = 0; i < 3; i++) begin
				mag_s5[i] <= cm[i];
				neg_s5[i] <= cr_s4[i][CW-1];
			end
			sh_s5 <= csh;
			deg_s5 <= deg_s4 || czero;
			for (int i = 0; i < 3; i++) begin
				mag_o[i] <= tfn_pkg::C_W'(mag_s5[i] >> sh_s5);
			end
			tag_o.neg <= neg_s5;
			tag_o.degen <= deg_s5;
		end
	end

	assign vld_o = vld_q[5];
endmodule

// ===== rtl/tfn_root.sv =====
module tfn_root (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   vld,
	input  logic [tfn_pkg::C_W-1:0] mag [3],
	input  tfn_pkg::tfn_tag_t      tag,
	output logic                   vld_o,
	output logic [tfn_pkg::Q_W-1:0] q_o [3],
	output tfn_pkg::tfn_tag_t      tag_o
);
	localparam int NS = tfn_pkg::Q_W;
	localparam int NST = NS + 2;

	logic [NST-1:0] vld_q;
	logic [tfn_pkg::SQ_W-1:0] sq_s1 [3];
	tfn_pkg::tfn_tag_t tag_st [NST];
	logic signed [tfn_pkg::P_W-1:0] s_st [NS+1];
	logic signed [tfn_pkg::P_W-1:0] r_st [NS+1][3];
	tfn_pkg::tfn_lane_t ln_st [NS+1][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], vld};
		end
	end

	always_ff @(posedge clk) begin
		logic signed [tfn_pkg::P_W-1:0] s;
		if (en) begin
			for (int i = 0; i < 3; i++) sq_s1[i] <= mag[i] * mag[i];
			tag_st[0] <= tag;
			s = tfn_pkg::P_W'(sq_s1[0]) + tfn_pkg::P_W'(sq_s1[1]) + tfn_pkg::P_W'(sq_s1[2]);
			s_st[0] <= s;
			tag_st[1] <= tag_st[0];
			for (int i = 0; i < 3; i++) begin
				r_st[0][i] <= tfn_pkg::P_W'(sq_s1[i]) <<< tfn_pkg::R_SHIFT;
				ln_st[0][i].p <= s;
				ln_st[0][i].m <= -s;
				ln_st[0][i].q <= '0;
			end
		end
	end

	// Greedy bit search, one bit of q per stage, MSB first
	for (genvar j = 0; j < NS; j++) begin : g_step
		localparam int K = NS - 1 - j;
		always_ff @(posedge clk) begin
			logic signed [tfn_pkg::P_W-1:0] pn;
			if (en) begin
				s_st[j+1] <= s_st[j];
				tag_st[j+2] <= tag_st[j+1];
				for (int i = 0; i < 3; i++) begin
					r_st[j+1][i] <= r_st[j][i];
					pn = ln_st[j][i].p + (ln_st[j][i].m <<< (K + 2)) + (s_st[j] <<< (2 * K + 2));
					if (pn <= r_st[j][i]) begin
						ln_st[j+1][i].p <= pn;
						ln_st[j+1][i].m <= ln_st[j][i].m + (s_st[j] <<< (K + 1));
						ln_st[j+1][i].q <= ln_st[j][i].q | tfn_pkg::Q_W'(1 << K);
					end else begin
						ln_st[j+1][i] <= ln_st[j][i];
					end
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) q_o[i] = ln_st[NS][i].q;
	end
	assign tag_o = tag_st[NST-1];
	assign vld_o = vld_q[NST-1];
endmodule

// ===== rtl/triangle_face_normal.sv =====
// channel   dir  modport          payload
// tri_in    in   tfn_tri_if.sink  a_x..c_z, signed Q8.8, COORD_WIDTH bits
// nrm_out   out  tfn_nrm_if.source normal_x/y/z signed Q1.14, degenerate
//
// One triangle per cycle while nrm_out is not stalled; stages are edges, prescale,
// cross product, magnitude prescale, squares, 15 stages of bit search for the unit
// magnitude, output register. arst_n clears the valid bits only. A stall at nrm_out
// holds the whole pipeline; bubbles inside it stay in place.
module triangle_face_normal #(
	parameter int COORD_WIDTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	tfn_tri_if.sink    tri_in,
	tfn_nrm_if.source  nrm_out
);
	logic en;
	logic signed [COORD_WIDTH-1:0] a [3], b [3], c [3];
	logic vld_c, vld_r;
	logic [tfn_pkg::C_W-1:0] mag_c [3];
	logic [tfn_pkg::Q_W-1:0] q_r [3];
	tfn_pkg::tfn_tag_t tag_c, tag_r;
	logic valid_q;
	logic signed [tfn_pkg::OUT_W-1:0] n_q [3];
	logic degen_q;

	assign en = !valid_q || nrm_out.ready;
	assign tri_in.ready = en;

	assign a = '{tri_in.a_x, tri_in.a_y, tri_in.a_z};
	assign b = '{tri_in.b_x, tri_in.b_y, tri_in.b_z};
	assign c = '{tri_in.c_x, tri_in.c_y, tri_in.c_z};

	tfn_cross #(.W(COORD_WIDTH)) u_cross (
		.clk, .arst_n, .en,
		.vld(tri_in.valid), .a, .b, .c,
		.vld_o(vld_c), .mag_o(mag_c), .tag_o(tag_c)
	);

	tfn_root u_root (
		.clk, .arst_n, .en,
		.vld(vld_c), .mag(mag_c), .tag(tag_c),
		.vld_o(vld_r), .q_o(q_r), .tag_o(tag_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= vld_r;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [tfn_pkg::OUT_W-1:0] v;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				v = $signed(tfn_pkg::OUT_W'(q_r[i]));
				if (tag_r.degen) n_q[i] <= '0;
				else n_q[i] <= tag_r.neg[i] ? -v : v;
			end
			degen_q <= tag_r.degen;
		end
	end

	assign nrm_out.valid = valid_q;
	assign nrm_out.normal_x = n_q[0];
	assign nrm_out.normal_y = n_q[1];
	assign nrm_out.normal_z = n_q[2];
	assign nrm_out.degenerate = degen_q;
endmodule
